// ===== sv/updsan_pkg.sv =====
// Package for the URL percent decoder with filename sanitizing.
// Holds widths, character codes, register indexes and the character helpers.
// No dependencies.
package updsan_pkg;

  localparam int BYTE_W     = 8;
  localparam int LIMIT_W    = 12;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;
  localparam int MAX_RES    = 3;
  localparam int LIMIT_FULL = 2 ** LIMIT_W - 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SANITIZE  = 4'd1;

  localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST = 12'd255;

  // escape tracking codes
  localparam logic [1:0] PC_IDLE = 2'd0;
  localparam logic [1:0] PC_ONE  = 2'd1;
  localparam logic [1:0] PC_TWO  = 2'd2;

  localparam logic [BYTE_W-1:0] CH_PERCENT    = 8'h25;
  localparam logic [BYTE_W-1:0] CH_PLUS       = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_BSLASH     = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_SLASH      = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_COLON      = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_STAR       = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_QUESTION   = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_DQUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] CH_LESS       = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_GREATER    = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_PIPE       = 8'h7C;

  function automatic logic is_hex(input logic [BYTE_W-1:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic logic [BYTE_W-1:0] sanitize(input logic en, input logic [BYTE_W-1:0] c);
    logic bad;
    bad = (c inside {CH_BSLASH, CH_SLASH, CH_COLON, CH_STAR, CH_QUESTION,
                     CH_DQUOTE, CH_LESS, CH_GREATER, CH_PIPE});
    return (en && bad) ? CH_UNDERSCORE : c;
  endfunction

endpackage

// ===== sv/updsan_in_if.sv =====
// Input channel of the URL decoder: one raw byte or an end mark per transaction.
// Depends on updsan_pkg.
interface updsan_in_if import updsan_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              is_end;

  modport source (output valid, output in_byte, output is_end, input ready);
  modport sink   (input valid, input in_byte, input is_end, output ready);
endinterface

// ===== sv/updsan_out_if.sv =====
// Result channel of the URL decoder: one decoded byte or terminator per transaction.
// Depends on updsan_pkg.
interface updsan_out_if import updsan_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              is_terminator;
  logic              last;

  modport source (output valid, output out_byte, output is_terminator, output last,
                  input ready);
  modport sink   (input valid, input out_byte, input is_terminator, input last,
                  output ready);
endinterface

// ===== sv/url_percent_decode_sanitize_top.sv =====
// URL percent decoder with filename sanitizing, top level.
// Path: an input transaction passes through the input register, then the result queue.
// Throughput: one item per cycle while each item gives at most one result and the output
// is not stalled; an item that gives two or three results holds the input (3-slot queue).
// Reset: synchronous, active low; clears escape state, count, queue and config to defaults.
// Depends on updsan_pkg, updsan_in_if, updsan_out_if.
module url_percent_decode_sanitize_top import updsan_pkg::*; #(
  parameter int LIMIT_MAX = 4095
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  updsan_in_if.sink             in_if,
  updsan_out_if.source          out_if
);

  localparam logic [LIMIT_W-1:0] LIM_CAP =
    (LIMIT_MAX < LIMIT_FULL) ? LIMIT_W'(LIMIT_MAX) : LIMIT_W'(LIMIT_FULL);

  logic [LIMIT_W-1:0] out_limit_r;
  logic               sanitize_en_r;

  logic               in_vld_r;
  logic [BYTE_W-1:0]  in_byte_r;
  logic               in_end_r;

  logic [1:0]         pc_r, pc_nxt;
  logic [BYTE_W-1:0]  fd_r, fd_nxt;
  logic [LIMIT_W-1:0] ec_r, ec_nxt;

  logic [1:0]         q_cnt_r, q_cnt_nxt;
  logic [BYTE_W-1:0]  q_byte_r [MAX_RES];
  logic               q_term_r [MAX_RES];
  logic [BYTE_W-1:0]  new_byte [MAX_RES];
  logic               new_term [MAX_RES];

  logic [BYTE_W-1:0]  cand [MAX_RES];
  logic [1:0]         ncand, nemit;
  logic [LIMIT_W-1:0] lim, avail;
  logic               plain_pct;
  logic [BYTE_W-1:0]  plain_val;
  logic               advance, out_take;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_limit_r   <= OUT_LIMIT_RST;
      sanitize_en_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_OUT_LIMIT) begin
        out_limit_r <= cfg_data[LIMIT_W-1:0];
      end else if (cfg_idx == CFG_SANITIZE) begin
        sanitize_en_r <= cfg_data[0];
      end
    end
  end

  assign out_take    = out_if.valid && out_if.ready;
  // load the queue when it is empty or empties this cycle
  assign advance     = in_vld_r && ((q_cnt_r == 2'd0) || ((q_cnt_r == 2'd1) && out_if.ready));
  assign in_if.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_byte_r <= in_if.in_byte;
      in_end_r  <= in_if.is_end;
    end
  end

  // candidate bytes before the limit
  always_comb begin
    plain_pct = (in_byte_r == CH_PERCENT);
    plain_val = (in_byte_r == CH_PLUS) ? CH_SPACE : in_byte_r;
    cand      = '{default: '0};
    ncand     = 2'd0;
    pc_nxt    = pc_r;
    fd_nxt    = fd_r;
    if (in_end_r) begin
      cand[0] = CH_PERCENT;
      cand[1] = fd_r;
      ncand   = (pc_r == PC_TWO) ? 2'd2 : ((pc_r == PC_ONE) ? 2'd1 : 2'd0);
      pc_nxt  = PC_IDLE;
      fd_nxt  = '0;
    end else begin
      case (pc_r)
        PC_ONE: begin
          if (is_hex(in_byte_r)) begin
            fd_nxt = in_byte_r;
            pc_nxt = PC_TWO;
          end else begin
            cand[0] = CH_PERCENT;
            cand[1] = plain_val;
            ncand   = plain_pct ? 2'd1 : 2'd2;
            pc_nxt  = plain_pct ? PC_ONE : PC_IDLE;
          end
        end
        PC_TWO: begin
          if (is_hex(in_byte_r) && is_hex(fd_r)) begin
            cand[0] = {hex_val(fd_r), hex_val(in_byte_r)};
            ncand   = 2'd1;
            pc_nxt  = PC_IDLE;
          end else begin
            cand[0] = CH_PERCENT;
            cand[1] = fd_r;
            cand[2] = plain_val;
            ncand   = plain_pct ? 2'd2 : 2'd3;
            pc_nxt  = plain_pct ? PC_ONE : PC_IDLE;
          end
        end
        default: begin
          cand[0] = plain_val;
          ncand   = plain_pct ? 2'd0 : 2'd1;
          pc_nxt  = plain_pct ? PC_ONE : PC_IDLE;
        end
      endcase
    end
  end

  // apply the limit, sanitize, append the terminator
  always_comb begin
    lim    = (out_limit_r < LIM_CAP) ? out_limit_r : LIM_CAP;
    avail  = (lim > ec_r) ? (lim - ec_r) : '0;
    nemit  = (avail < {{(LIMIT_W-2){1'b0}}, ncand}) ? avail[1:0] : ncand;
    ec_nxt = in_end_r ? '0 : (ec_r + {{(LIMIT_W-2){1'b0}}, nemit});
    for (int i = 0; i < MAX_RES; i++) begin
      new_byte[i] = sanitize(sanitize_en_r, cand[i]);
      new_term[i] = 1'b0;
      if (in_end_r && (2'(i) == nemit)) begin
        new_byte[i] = '0;
        new_term[i] = 1'b1;
      end
    end
  end

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (advance) begin
      q_cnt_nxt = nemit + {1'b0, in_end_r};
    end else if (out_take) begin
      q_cnt_nxt = q_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= PC_IDLE;
      fd_r    <= '0;
      ec_r    <= '0;
      q_cnt_r <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (advance) begin
        pc_r <= pc_nxt;
        fd_r <= fd_nxt;
        ec_r <= ec_nxt;
      end
    end
  end

  // result queue: load a whole burst, shift down on each taken transaction
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < MAX_RES; i++) begin
        q_byte_r[i] <= new_byte[i];
        q_term_r[i] <= new_term[i];
      end
    end else if (out_take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        q_byte_r[i] <= q_byte_r[i+1];
        q_term_r[i] <= q_term_r[i+1];
      end
    end
  end

  assign out_if.valid         = (q_cnt_r != 2'd0);
  assign out_if.out_byte      = q_byte_r[0];
  assign out_if.is_terminator = q_term_r[0];
  assign out_if.last          = (q_cnt_r == 2'd1);

endmodule

// ===== sv/updsan_checker.sv =====
// Port-level checks for the URL decoder top level, with the bind that attaches them.
// Depends on url_percent_decode_sanitize_top and its channel interfaces.
module updsan_port_checks import updsan_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_byte,
  input logic              out_term,
  input logic              out_last
);

  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_term |-> out_last)
    else $error("terminator is not the last result of its item");

  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_term |-> out_byte == '0)
    else $error("terminator carries a nonzero byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_term) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind url_percent_decode_sanitize_top updsan_port_checks u_updsan_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_byte  (out_if.out_byte),
  .out_term  (out_if.is_terminator),
  .out_last  (out_if.last)
);
